// ===== rtl/rsi_pkg.sv =====
// Shared widths, payload types and latency figures for the ray-sphere test pipeline.
// No dependencies; imported by every module of the block.
package rsi_pkg;

    localparam int COORD_W  = 32;
    localparam int DIR_W    = 18;
    localparam int RAD_W    = 31;
    localparam int M_W      = COORD_W + 1;
    localparam int P_W      = M_W + DIR_W;
    localparam int Q_W      = 2 * M_W - 1;
    localparam int RR_W     = 2 * RAD_W;
    localparam int B_W      = 53;
    localparam int C_W      = 68;
    localparam int HALF_W   = 26;
    localparam int PP_W     = 2 * HALF_W;
    localparam int ROOT_W   = 52;
    localparam int DISC_W   = 2 * ROOT_W;
    localparam int DSGN_W   = DISC_W + 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int TW_W     = 54;
    localparam int TQ_W     = 38;
    localparam int DFRAC    = 16;
    localparam int PROD_W   = DIR_W + TQ_W + 1;
    localparam int STEP_W   = PROD_W - DFRAC;
    localparam int SUM_W    = STEP_W + 1;

    localparam int DOT_LAT  = 6;
    localparam int PT_LAT   = 4;
    localparam int LATENCY  = DOT_LAT + ROOT_W + PT_LAT;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] org;
        logic [2:0][DIR_W-1:0]   dir;
        logic [B_W-1:0]          b;
        logic                    miss;
    } t_side;

endpackage

// ===== rtl/rsi_dot.sv =====
// Front stages: offset, dot products, b squared and the discriminant.
// Depends on rsi_pkg.
module rsi_dot import rsi_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [2:0][COORD_W-1:0]   i_org,
    input  logic [2:0][DIR_W-1:0]     i_dir,
    input  logic [2:0][COORD_W-1:0]   i_ctr,
    input  logic [RAD_W-1:0]          i_rad,
    output logic                      o_vld,
    output logic [DISC_W-1:0]         o_disc,
    output t_side                     o_side
);

    logic [DOT_LAT-1:0] r_vld;
    t_side r_side [DOT_LAT];

    logic signed [M_W-1:0] r1_m [3];
    logic [RAD_W-1:0]      r1_rad;
    logic signed [M_W-1:0] n1_m [3];

    logic signed [P_W-1:0] r2_p [3];
    logic [Q_W-2:0]        r2_q [3];
    logic [RR_W-1:0]       r2_rr;
    logic signed [P_W-1:0] n2_p [3];
    logic [Q_W-2:0]        n2_q [3];
    logic signed [Q_W-1:0] w2_sq [3];

    logic signed [C_W-1:0] r3_c;
    logic signed [B_W-1:0] n3_b;
    logic signed [C_W-1:0] n3_c;

    logic [PP_W-1:0]       r4_hh, r4_hl, r4_ll;
    logic signed [C_W-1:0] r4_c;
    logic                  r4_miss;
    logic [B_W-2:0]        w4_ab;
    logic signed [B_W-1:0] w4_b;

    logic [DISC_W-1:0]     r5_b2;
    logic signed [C_W-1:0] r5_c;
    logic                  r5_miss;

    logic [DISC_W-1:0]     r6_disc;
    logic [DSGN_W-1:0]     w6_d;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_m[i] = $signed({i_org[i][COORD_W-1], i_org[i]})
                    - $signed({i_ctr[i][COORD_W-1], i_ctr[i]});
            n2_p[i] = r1_m[i] * $signed(r_side[0].dir[i]);
            w2_sq[i] = r1_m[i] * r1_m[i];
            n2_q[i] = w2_sq[i][Q_W-2:0];
        end
        n3_b = {{(B_W-P_W){r2_p[0][P_W-1]}}, r2_p[0]}
             + {{(B_W-P_W){r2_p[1][P_W-1]}}, r2_p[1]}
             + {{(B_W-P_W){r2_p[2][P_W-1]}}, r2_p[2]};
        n3_c = $signed({{(C_W-Q_W+1){1'b0}}, r2_q[0]})
             + $signed({{(C_W-Q_W+1){1'b0}}, r2_q[1]})
             + $signed({{(C_W-Q_W+1){1'b0}}, r2_q[2]})
             - $signed({{(C_W-RR_W){1'b0}}, r2_rr});
        w4_b = $signed(r_side[2].b);
        w4_ab = w4_b[B_W-1] ? (B_W-1)'(-w4_b) : (B_W-1)'(w4_b);
        w6_d = {2'b00, r5_b2} - {{(DSGN_W-C_W-32){r5_c[C_W-1]}}, r5_c, 32'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DOT_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0].org  <= i_org;
        r_side[0].dir  <= i_dir;
        r_side[0].b    <= '0;
        r_side[0].miss <= 1'b0;
        r1_m   <= n1_m;
        r1_rad <= i_rad;

        r_side[1] <= r_side[0];
        r2_p  <= n2_p;
        r2_q  <= n2_q;
        r2_rr <= r1_rad * r1_rad;

        r_side[2] <= '{org: r_side[1].org, dir: r_side[1].dir, b: n3_b,
                       miss: r_side[1].miss};
        r3_c <= n3_c;

        r_side[3] <= r_side[2];
        r4_hh <= w4_ab[2*HALF_W-1:HALF_W] * w4_ab[2*HALF_W-1:HALF_W];
        r4_hl <= w4_ab[2*HALF_W-1:HALF_W] * w4_ab[HALF_W-1:0];
        r4_ll <= w4_ab[HALF_W-1:0] * w4_ab[HALF_W-1:0];
        r4_c  <= r3_c;
        r4_miss <= (r3_c > 0) && (w4_b > 0);

        r_side[4] <= r_side[3];
        r5_b2 <= {r4_hh, {PP_W{1'b0}}}
               + {{(DISC_W-PP_W-HALF_W-1){1'b0}}, r4_hl, {(HALF_W+1){1'b0}}}
               + {{(DISC_W-PP_W){1'b0}}, r4_ll};
        r5_c    <= r4_c;
        r5_miss <= r4_miss;

        r_side[5] <= '{org: r_side[4].org, dir: r_side[4].dir, b: r_side[4].b,
                       miss: r5_miss || w6_d[DSGN_W-1]};
        r6_disc <= (r5_miss || w6_d[DSGN_W-1]) ? '0 : w6_d[DISC_W-1:0];
    end

    assign o_vld  = r_vld[DOT_LAT-1];
    assign o_disc = r6_disc;
    assign o_side = r_side[DOT_LAT-1];

endmodule

// ===== rtl/rsi_sqrt.sv =====
// Floor square root of the discriminant, one root bit per register stage.
// Depends on rsi_pkg; carries the side payload alongside.
module rsi_sqrt import rsi_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [DISC_W-1:0]  i_disc,
    input  t_side              i_side,
    output logic               o_vld,
    output logic [ROOT_W-1:0]  o_root,
    output t_side              o_side
);

    logic              r_vld  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [DISC_W-1:0] r_x    [ROOT_W];
    t_side             r_side [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        logic              a_vld;
        logic [REM_W-1:0]  a_rem;
        logic [ROOT_W-1:0] a_root;
        logic [DISC_W-1:0] a_x;
        t_side             a_side;
        logic [REM_W-1:0]  w_sh, w_trial, n_rem;
        logic [ROOT_W-1:0] n_root;

        if (j == 0) begin : g_first
            assign a_vld  = i_vld;
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_x    = i_disc;
            assign a_side = i_side;
        end else begin : g_next
            assign a_vld  = r_vld[j-1];
            assign a_rem  = r_rem[j-1];
            assign a_root = r_root[j-1];
            assign a_x    = r_x[j-1];
            assign a_side = r_side[j-1];
        end

        always_comb begin
            w_sh    = {a_rem[REM_W-3:0], a_x[DISC_W-1 -: 2]};
            w_trial = {a_root, 2'b01};
            if (w_sh >= w_trial) begin
                n_rem  = w_sh - w_trial;
                n_root = {a_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_sh;
                n_root = {a_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= n_rem;
            r_root[j] <= n_root;
            r_x[j]    <= {a_x[DISC_W-3:0], 2'b00};
            r_side[j] <= a_side;
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

// ===== rtl/rsi_point.sv =====
// Back stages: hit distance, rounding and the saturated hit point.
// Depends on rsi_pkg.
module rsi_point import rsi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic [ROOT_W-1:0]        i_root,
    input  t_side                    i_side,
    output logic                     o_vld,
    output logic                     o_hit,
    output logic [COORD_W-1:0]       o_dist,
    output logic [2:0][COORD_W-1:0]  o_pt
);

    localparam logic [TW_W:0]     RND_T = (TW_W+1)'(1) << (DFRAC - 1);
    localparam logic [PROD_W-1:0] RND_P = PROD_W'(1) << (DFRAC - 1);

    logic [PT_LAT-1:0] r_vld;
    t_side r_side [PT_LAT-1];

    logic [TW_W-1:0]         r1_tw;
    logic signed [TW_W:0]    w1_tw;
    logic [TQ_W-1:0]         r2_tq;
    logic [TW_W:0]           w2_sum;
    logic signed [PROD_W-1:0] r3_prod [3];
    logic [COORD_W-1:0]      r3_dist;
    logic                    r4_hit;
    logic [COORD_W-1:0]      r4_dist;
    logic [COORD_W-1:0]      r4_pt [3];
    logic signed [PROD_W-1:0] w4_p [3];
    logic signed [SUM_W-1:0] w4_s [3];
    logic [COORD_W-1:0]      n4_pt [3];

    always_comb begin
        w1_tw = -$signed({{(TW_W+1-B_W){i_side.b[B_W-1]}}, i_side.b})
              - $signed({{(TW_W+1-ROOT_W){1'b0}}, i_root});
        w2_sum = {1'b0, r1_tw} + RND_T;
        for (int i = 0; i < 3; i++) begin
            w4_p[i] = r3_prod[i] + $signed(RND_P);
            w4_s[i] = $signed({{(SUM_W-COORD_W){r_side[2].org[i][COORD_W-1]}},
                               r_side[2].org[i]})
                    + $signed({w4_p[i][PROD_W-1], w4_p[i][PROD_W-1:DFRAC]});
            if (w4_s[i] > $signed({{(SUM_W-COORD_W){1'b0}}, 1'b0, {(COORD_W-1){1'b1}}})) begin
                n4_pt[i] = {1'b0, {(COORD_W-1){1'b1}}};
            end else if (w4_s[i] < $signed({{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}}))
            begin
                n4_pt[i] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                n4_pt[i] = w4_s[i][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PT_LAT-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        r1_tw <= w1_tw[TW_W] ? '0 : w1_tw[TW_W-1:0];

        r_side[1] <= r_side[0];
        r2_tq <= w2_sum[TQ_W+DFRAC-1:DFRAC];

        r_side[2] <= r_side[1];
        for (int i = 0; i < 3; i++) begin
            r3_prod[i] <= $signed(r_side[1].dir[i]) * $signed({1'b0, r2_tq});
        end
        r3_dist <= (|r2_tq[TQ_W-1:COORD_W]) ? '1 : r2_tq[COORD_W-1:0];

        r4_hit  <= !r_side[2].miss;
        r4_dist <= r_side[2].miss ? '0 : r3_dist;
        for (int i = 0; i < 3; i++) begin
            r4_pt[i] <= r_side[2].miss ? '0 : n4_pt[i];
        end
    end

    assign o_vld  = r_vld[PT_LAT-1];
    assign o_hit  = r4_hit;
    assign o_dist = r4_dist;
    assign o_pt   = {r4_pt[2], r4_pt[1], r4_pt[0]};

endmodule

// ===== rtl/ray_sphere_intersect.sv =====
// Ray against sphere test, fully pipelined; top level of the block.
// Depends on rsi_pkg, rsi_dot, rsi_sqrt and rsi_point.
//
//  channel  | handshake             | word
//  ---------+-----------------------+--------------------------------------------
//  request  | start, busy           | origin, dir, center, sphere_radius
//  result   | o_valid (one cycle)   | hit, hit_distance, hit_x/y/z
//
// One word enters per cycle, and results leave in the order of their starts.
// The latency is set by the square root: one root bit per stage, 52 stages, plus
// six front stages and four back stages. busy never rises; nothing stalls.
// Reset clears the valid bits of every stage; words in flight are dropped.
module ray_sphere_intersect import rsi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [COORD_W-1:0]  i_origin_x,
    input  logic [COORD_W-1:0]  i_origin_y,
    input  logic [COORD_W-1:0]  i_origin_z,
    input  logic [DIR_W-1:0]    i_dir_x,
    input  logic [DIR_W-1:0]    i_dir_y,
    input  logic [DIR_W-1:0]    i_dir_z,
    input  logic [COORD_W-1:0]  i_center_x,
    input  logic [COORD_W-1:0]  i_center_y,
    input  logic [COORD_W-1:0]  i_center_z,
    input  logic [RAD_W-1:0]    i_sphere_radius,
    output logic                o_valid,
    output logic                o_hit,
    output logic [COORD_W-1:0]  o_hit_distance,
    output logic [COORD_W-1:0]  o_hit_x,
    output logic [COORD_W-1:0]  o_hit_y,
    output logic [COORD_W-1:0]  o_hit_z
);

    logic                    w_dot_vld, w_sq_vld;
    logic [DISC_W-1:0]       w_disc;
    logic [ROOT_W-1:0]       w_root;
    t_side                   w_dot_side, w_sq_side;
    logic [2:0][COORD_W-1:0] w_pt;

    assign busy = 1'b0;

    rsi_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_org   ({i_origin_z, i_origin_y, i_origin_x}),
        .i_dir   ({i_dir_z, i_dir_y, i_dir_x}),
        .i_ctr   ({i_center_z, i_center_y, i_center_x}),
        .i_rad   (i_sphere_radius),
        .o_vld   (w_dot_vld),
        .o_disc  (w_disc),
        .o_side  (w_dot_side)
    );

    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_dot_vld),
        .i_disc  (w_disc),
        .i_side  (w_dot_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    rsi_point u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_sq_vld),
        .i_root  (w_root),
        .i_side  (w_sq_side),
        .o_vld   (o_valid),
        .o_hit   (o_hit),
        .o_dist  (o_hit_distance),
        .o_pt    (w_pt)
    );

    assign o_hit_x = w_pt[0];
    assign o_hit_y = w_pt[1];
    assign o_hit_z = w_pt[2];

endmodule

// ===== rtl/rsi_check.sv =====
// Port-level checks for ray_sphere_intersect, bound to the top level.
// Depends on rsi_pkg for the pipeline latency.
module rsi_check import rsi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [COORD_W-1:0]  i_origin_x,
    input  logic [COORD_W-1:0]  i_origin_y,
    input  logic [COORD_W-1:0]  i_origin_z,
    input  logic                o_valid,
    input  logic                o_hit,
    input  logic [COORD_W-1:0]  o_hit_distance,
    input  logic [COORD_W-1:0]  o_hit_x,
    input  logic [COORD_W-1:0]  o_hit_y,
    input  logic [COORD_W-1:0]  o_hit_z
);

    a_no_spurious: assert property (@(posedge i_clk)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result word without a matching start");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_distance == '0 && o_hit_x == '0
                                 && o_hit_y == '0 && o_hit_z == '0))
        else $error("miss word carries non-zero fields");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit && o_hit_distance == '0) |->
            (o_hit_x == $past(i_origin_x, LATENCY) && o_hit_y == $past(i_origin_y, LATENCY)
             && o_hit_z == $past(i_origin_z, LATENCY)))
        else $error("zero distance hit not at the ray origin");

endmodule

bind ray_sphere_intersect rsi_check u_rsi_check (.*);
